/* rtl/core/bpp_pkg.sv */
// ----------------------------------------------------------------------------
// bpp_pkg
// Shared constants and types of the biosignal packet parser.
// ----------------------------------------------------------------------------
package bpp_pkg;

  localparam int EEG_CHANNELS   = 8;
  localparam int ACCEL_CHANNELS = 3;
  localparam int TOTAL_VALUES   = EEG_CHANNELS + ACCEL_CHANNELS;

  localparam int BYTE_W   = 8;
  localparam int SAMPLE_W = 8;
  localparam int IDX_W    = 4;
  localparam int VALUE_W  = 24;
  localparam int ACCEL_W  = 16;

  // Two banks of the channel store, one per packet in flight.
  localparam int STORE_ADDR_W = IDX_W + 1;
  localparam int STORE_DEPTH  = 2 ** STORE_ADDR_W;

  localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hA0;
  localparam logic [BYTE_W-1:0] FTR_BYTE = 8'hC0;

  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(TOTAL_VALUES - 1);
  localparam logic [IDX_W-1:0] EEG_COUNT  = IDX_W'(EEG_CHANNELS);
  localparam logic [IDX_W-1:0] ACC_COUNT  = IDX_W'(ACCEL_CHANNELS);

  // Byte positions within a value, counted from zero.
  localparam logic [1:0] EEG_LAST_BYTE = 2'd2;
  localparam logic [1:0] ACC_LAST_BYTE = 2'd1;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_SEQNUM = 5'b00010,
    PH_EEG    = 5'b00100,
    PH_ACCEL  = 5'b01000,
    PH_FOOTER = 5'b10000
  } phase_t;

  // One finished packet, handed from the front to the back.
  typedef struct packed {
    logic                bank;
    logic [SAMPLE_W-1:0] sample;
    logic                gap;
  } cmd_t;

  typedef struct packed {
    logic                    en;
    logic [STORE_ADDR_W-1:0] addr;
    logic [VALUE_W-1:0]      data;
  } store_wr_t;

endpackage

/* rtl/core/bpp_ram.sv */
// ----------------------------------------------------------------------------
// bpp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/bpp_front.sv */
// ----------------------------------------------------------------------------
// bpp_front
// Byte deframer: tracks the packet phase, assembles values into the channel
// store and posts a request for each packet that ends in a good footer.
// ----------------------------------------------------------------------------
module bpp_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      byte_valid,
  input  logic [bpp_pkg::BYTE_W-1:0] byte_data,
  output bpp_pkg::store_wr_t        store_wr,
  output logic                      cmd_push,
  output bpp_pkg::cmd_t             cmd
);
  import bpp_pkg::*;

  phase_t              phase, phase_next;
  logic [IDX_W-1:0]    value_index, value_index_next;
  logic [1:0]          byte_index, byte_index_next;
  logic [VALUE_W-1:0]  assembly, assembly_next;
  logic [SAMPLE_W-1:0] held_sample, held_sample_next;
  logic [SAMPLE_W-1:0] prev_sample, prev_sample_next;
  logic                wr_bank, wr_bank_next;
  logic [IDX_W-1:0]    vi_inc;

  // The bank the back side still reads is never the one written here;
  // the top level only lets bytes in while a free bank exists.
  assign vi_inc = value_index + IDX_W'(1);

  always_comb begin
    phase_next       = phase;
    value_index_next = value_index;
    byte_index_next  = byte_index;
    assembly_next    = {assembly[VALUE_W-BYTE_W-1:0], byte_data};
    held_sample_next = held_sample;
    prev_sample_next = prev_sample;
    wr_bank_next     = wr_bank;
    store_wr         = '0;
    cmd_push         = 1'b0;
    cmd.bank         = wr_bank;
    cmd.sample       = held_sample;
    cmd.gap          = ((prev_sample + SAMPLE_W'(1)) != held_sample);

    if (byte_valid) begin
      case (phase)
        PH_HEADER: begin
          value_index_next = '0;
          byte_index_next  = '0;
          phase_next       = (byte_data == HDR_BYTE) ? PH_SEQNUM : PH_HEADER;
        end
        PH_SEQNUM: begin
          held_sample_next = byte_data;
          phase_next       = PH_EEG;
        end
        PH_EEG: begin
          byte_index_next = byte_index + 2'd1;
          if (byte_index == EEG_LAST_BYTE) begin
            store_wr.en      = 1'b1;
            store_wr.addr    = {wr_bank, value_index};
            store_wr.data    = assembly_next;
            byte_index_next  = '0;
            value_index_next = vi_inc;
            if (vi_inc >= EEG_COUNT) begin
              phase_next       = PH_ACCEL;
              value_index_next = '0;
            end
          end
        end
        PH_ACCEL: begin
          byte_index_next = byte_index + 2'd1;
          if (byte_index == ACC_LAST_BYTE) begin
            store_wr.en      = 1'b1;
            store_wr.addr    = {wr_bank, EEG_COUNT + value_index};
            store_wr.data    = {{(VALUE_W-ACCEL_W){assembly_next[ACCEL_W-1]}},
                                assembly_next[ACCEL_W-1:0]};
            byte_index_next  = '0;
            value_index_next = vi_inc;
            if (vi_inc >= ACC_COUNT) begin
              phase_next = PH_FOOTER;
            end
          end
        end
        PH_FOOTER: begin
          if (byte_data == FTR_BYTE) begin
            cmd_push         = 1'b1;
            prev_sample_next = held_sample;
            wr_bank_next     = ~wr_bank;
          end
          phase_next = PH_HEADER;
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      value_index <= '0;
      byte_index  <= '0;
      held_sample <= '0;
      prev_sample <= '0;
      wr_bank     <= 1'b0;
    end else begin
      phase       <= phase_next;
      value_index <= value_index_next;
      byte_index  <= byte_index_next;
      held_sample <= held_sample_next;
      prev_sample <= prev_sample_next;
      wr_bank     <= wr_bank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid) begin
      assembly <= assembly_next;
    end
  end

endmodule

/* rtl/core/bpp_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// bpp_cmd_fifo
// Two-entry queue of finished packets, one entry per store bank.
// ----------------------------------------------------------------------------
module bpp_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bpp_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          head_valid,
  output bpp_pkg::cmd_t head_cmd,
  output logic          full
);
  import bpp_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head_valid = (count != 2'd0);
  assign full       = (count == 2'd2);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* rtl/core/bpp_back.sv */
// ----------------------------------------------------------------------------
// bpp_back
// Result sequencer: reads the eleven values of the head packet from the
// store and presents them through an output register.
// ----------------------------------------------------------------------------
module bpp_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                head_valid,
  input  bpp_pkg::cmd_t                       head_cmd,
  output logic                                pop,
  output logic                                rd_en,
  output logic [bpp_pkg::STORE_ADDR_W-1:0]    rd_addr,
  input  logic [bpp_pkg::VALUE_W-1:0]         rd_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bpp_pkg::SAMPLE_W-1:0]        sample_number,
  output logic [bpp_pkg::IDX_W-1:0]           channel_index,
  output logic signed [bpp_pkg::VALUE_W-1:0]  sample_value,
  output logic                                gap_seen,
  output logic                                last_of_packet
);
  import bpp_pkg::*;

  logic [IDX_W-1:0]    iss_k;
  logic                rd_v;
  logic [IDX_W-1:0]    rd_k;
  logic [SAMPLE_W-1:0] rd_sample;
  logic                rd_gap;
  logic                rd_last;
  logic                out_load;

  // The RAM read data holds while no new read is issued, so the read stage
  // may wait for the output register without losing its value.
  assign out_load = rd_v && (!out_valid || out_ready);
  assign rd_en    = head_valid && (!rd_v || out_load);
  assign rd_addr  = {head_cmd.bank, iss_k};
  assign pop      = rd_en && (iss_k == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_k     <= '0;
      rd_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rd_en) begin
        iss_k <= pop ? '0 : iss_k + IDX_W'(1);
      end
      if (rd_en) begin
        rd_v <= 1'b1;
      end else if (out_load) begin
        rd_v <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_k      <= iss_k;
      rd_sample <= head_cmd.sample;
      rd_gap    <= head_cmd.gap;
      rd_last   <= (iss_k == LAST_IDX);
    end
    if (out_load) begin
      sample_number  <= rd_sample;
      channel_index  <= rd_k;
      sample_value   <= rd_data;
      gap_seen       <= rd_gap;
      last_of_packet <= rd_last;
    end
  end

endmodule

/* rtl/core/biosignal_packet_parser.sv */
// ----------------------------------------------------------------------------
// biosignal_packet_parser
// Deframes 33-byte biosignal packets from a serial byte stream and emits
// the eight EEG and three accelerometer values of every good packet.
// ----------------------------------------------------------------------------
//
//   channel   handshake              payload
//   -------   --------------------   -----------------------------------------
//   input     in_valid / in_ready    rx_byte
//   output    out_valid / out_ready  sample_number, channel_index,
//                                    sample_value, gap_seen, last_of_packet
//
// The front takes one byte per cycle while in_ready is high; values land in a two-bank store.
// A good footer queues the packet; the back then streams its eleven values,
// one per cycle while out_ready is high, paced by the store's single
// registered read port.
// in_ready drops only while two finished packets still wait to be read out.
// Reset clears the parse phase, counters, sample history and the queue.
// ----------------------------------------------------------------------------
module biosignal_packet_parser (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bpp_pkg::BYTE_W-1:0]          rx_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bpp_pkg::SAMPLE_W-1:0]        sample_number,
  output logic [bpp_pkg::IDX_W-1:0]           channel_index,
  output logic signed [bpp_pkg::VALUE_W-1:0]  sample_value,
  output logic                                gap_seen,
  output logic                                last_of_packet
);
  import bpp_pkg::*;

  store_wr_t               store_wr;
  logic                    cmd_push;
  cmd_t                    push_cmd;
  logic                    cmd_pop;
  logic                    head_valid;
  cmd_t                    head_cmd;
  logic                    cmd_full;
  logic                    rd_en;
  logic [STORE_ADDR_W-1:0] rd_addr;
  logic [VALUE_W-1:0]      rd_data;
  logic                    byte_fire;

  assign in_ready  = !cmd_full;
  assign byte_fire = in_valid && in_ready;

  bpp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_fire),
    .byte_data  (rx_byte),
    .store_wr   (store_wr),
    .cmd_push   (cmd_push),
    .cmd        (push_cmd)
  );

  bpp_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_wr.en),
    .waddr (store_wr.addr),
    .wdata (store_wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  bpp_cmd_fifo u_cmd_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_push),
    .push_cmd   (push_cmd),
    .pop        (cmd_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .full       (cmd_full)
  );

  bpp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_cmd       (head_cmd),
    .pop            (cmd_pop),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sample_number  (sample_number),
    .channel_index  (channel_index),
    .sample_value   (sample_value),
    .gap_seen       (gap_seen),
    .last_of_packet (last_of_packet)
  );

`ifndef SYNTHESIS
  // A finished packet must always find room in the queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full)
    else $error("packet queue overflow");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_of_packet) |-> (channel_index == LAST_IDX))
    else $error("last_of_packet on a wrong channel");

  // Within one packet the sample number and gap flag do not change.
  a_packet_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_of_packet) |=>
      (!out_valid || ((sample_number == $past(sample_number)) &&
                      (gap_seen == $past(gap_seen)))))
    else $error("packet fields changed inside a packet");
`endif

endmodule
